FILE: hdl/alld_pkg.sv
// shared types and constants for the affinity least-loaded dispatcher
// no dependencies; imported by every module of the block
package alld_pkg;

    localparam int CFG_BITS = 4;
    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 4'd8;

    typedef enum logic {
        OP_SUBMIT = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_ASSIGNED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_DONE     = 2'd2
    } t_kind;

    typedef struct packed {
        t_op         op;
        logic [15:0] source_id;
        logic [2:0]  worker_id;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  worker;
        logic [15:0] source_echo;
    } t_out_item;

    // classified item as held in the queue
    typedef struct packed {
        logic        finish;
        logic        wid_known;
        logic [15:0] source_id;
        logic [2:0]  worker_id;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_OUT
    } t_state;

endpackage

FILE: hdl/alld_front.sv
// front stage: accepts items and classifies them into queue jobs
// depends on alld_pkg
module alld_front #(
    parameter int WORKERS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  alld_pkg::t_in_item i_item,
    output logic              o_job_vld,
    output alld_pkg::t_job    o_job,
    input  logic              i_job_full
);
    import alld_pkg::*;

    logic r_vld;
    t_job r_job;
    t_job n_job;
    logic w_pass;
    logic w_ready;

    assign w_pass  = r_vld && !i_job_full;
    assign w_ready = !r_vld || w_pass;
    assign o_stall = !w_ready;

    always_comb begin
        n_job.finish    = (i_item.op == OP_FINISH);
        n_job.wid_known = (i_item.op == OP_FINISH) && (int'(i_item.worker_id) < WORKERS);
        n_job.source_id = i_item.source_id;
        n_job.worker_id = i_item.worker_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_job <= n_job;
        end
    end

    assign o_job_vld = r_vld;
    assign o_job     = r_job;

endmodule

FILE: hdl/alld_queue.sv
// two-entry job queue between front and back
// depends on alld_pkg
module alld_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  alld_pkg::t_job i_push_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output alld_pkg::t_job o_head
);
    import alld_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

FILE: hdl/alld_back.sv
// back engine: affinity table scan, least-loaded search, load update, result register
// depends on alld_pkg
module alld_back #(
    parameter int WORKERS    = 8,
    parameter int SOURCES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [alld_pkg::CFG_BITS-1:0]   i_active,
    input  alld_pkg::t_job                  i_job,
    input  logic                            i_job_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output alld_pkg::t_out_item             o_result
);
    import alld_pkg::*;

    localparam int WIDX  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int SIDX  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int NSCAN = (WORKERS < (2**CFG_BITS - 1)) ? WORKERS : (2**CFG_BITS - 1);
    localparam int STEPS = (SOURCES > NSCAN) ? SOURCES : NSCAN;
    localparam int KBITS = $clog2(STEPS + 1);
    localparam logic [CFG_BITS-1:0] NMAX = CFG_BITS'(NSCAN);

    // affinity table storage
    logic [15:0]           mem_src  [SOURCES];
    logic [COUNT_BITS-1:0] mem_pend [SOURCES];
    logic [2:0]            mem_wkr  [SOURCES];
    logic [SOURCES-1:0]    r_ent_vld;
    logic [15:0]           r_rd_src;
    logic [COUNT_BITS-1:0] r_rd_pend;
    logic [2:0]            r_rd_wkr;

    // worker load storage
    logic [COUNT_BITS-1:0] mem_load [WORKERS];
    logic [WORKERS-1:0]    r_lvld;
    logic [COUNT_BITS-1:0] r_rd_load;

    t_state                r_state;
    t_state                n_state;
    t_job                  r_job;
    logic [CFG_BITS-1:0]   r_n;
    logic [KBITS-1:0]      r_k;
    logic                  r_found;
    logic [SIDX-1:0]       r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_pend;
    logic [2:0]            r_hit_wkr;
    logic                  r_free_found;
    logic [SIDX-1:0]       r_free_idx;
    logic [COUNT_BITS-1:0] r_best;
    logic [WIDX-1:0]       r_best_idx;
    logic [WIDX-1:0]       r_tgt;
    logic                  r_tgt_inc;
    t_out_item             r_res;
    logic                  r_out_vld;
    t_out_item             r_out;

    logic [CFG_BITS-1:0]   w_n_clamp;
    logic [KBITS-1:0]      w_t;
    logic                  w_eval;
    logic                  w_hit;
    logic                  w_free;
    logic                  w_ld_in;
    logic                  w_better;
    logic [SIDX-1:0]       w_taddr;
    logic [WIDX-1:0]       w_laddr;
    logic                  w_out_load;

    // decide-phase controls
    logic                  w_tab_we;
    logic [SIDX-1:0]       w_tab_idx;
    logic                  w_tab_new;
    logic [COUNT_BITS-1:0] w_tab_pend;
    logic [2:0]            w_tab_wkr;
    logic                  w_ent_set;
    logic                  w_ent_clr;
    logic                  w_ld_go;
    logic [WIDX-1:0]       w_ld_tgt;
    logic                  w_ld_inc;
    t_out_item             w_res;
    logic [COUNT_BITS-1:0] w_load_nxt;

    always_comb begin
        priority if (i_active == '0) begin
            w_n_clamp = CFG_BITS'(1);
        end else if (i_active > NMAX) begin
            w_n_clamp = NMAX;
        end else begin
            w_n_clamp = i_active;
        end
    end

    // scan evaluates the entry and load read in the previous cycle
    assign w_t      = r_k - KBITS'(1);
    assign w_eval   = (r_k != '0);
    assign w_hit    = w_eval && (int'(w_t) < SOURCES) && r_ent_vld[SIDX'(w_t)]
                      && (r_rd_src == r_job.source_id);
    assign w_free   = w_eval && (int'(w_t) < SOURCES) && !r_ent_vld[SIDX'(w_t)];
    assign w_ld_in  = w_eval && (int'(w_t) < int'(r_n));
    assign w_better = (w_t == '0) || (r_rd_load < r_best);
    assign w_taddr  = SIDX'(r_k);
    assign w_laddr  = (r_state == ST_SCAN) ? WIDX'(r_k) : r_tgt;

    assign w_out_load = (r_state == ST_OUT) && (!r_out_vld || !i_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_k == KBITS'(STEPS)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = w_ld_go ? ST_LOAD_RD : ST_OUT;
            end
            ST_LOAD_RD: n_state = ST_LOAD_WR;
            ST_LOAD_WR: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and decide-phase controls
    always_comb begin
        o_pop      = (r_state == ST_IDLE) && !i_job_empty;
        w_tab_we   = 1'b0;
        w_tab_idx  = r_hit_idx;
        w_tab_new  = 1'b0;
        w_tab_pend = (&r_hit_pend) ? r_hit_pend : r_hit_pend + COUNT_BITS'(1);
        w_tab_wkr  = r_hit_wkr;
        w_ent_set  = 1'b0;
        w_ent_clr  = 1'b0;
        w_ld_go    = 1'b0;
        w_ld_tgt   = WIDX'(r_hit_wkr);
        w_ld_inc   = 1'b1;
        w_res.kind        = KIND_DONE;
        w_res.worker      = 3'd0;
        w_res.source_echo = r_job.source_id;
        if (r_state == ST_DECIDE) begin
            if (!r_job.finish) begin
                priority if (r_found) begin
                    // sticky worker, even if no longer active
                    w_tab_we     = 1'b1;
                    w_ld_go      = (int'(r_hit_wkr) < WORKERS);
                    w_res.kind   = KIND_ASSIGNED;
                    w_res.worker = r_hit_wkr;
                end else if (r_free_found) begin
                    w_tab_we     = 1'b1;
                    w_tab_new    = 1'b1;
                    w_tab_idx    = r_free_idx;
                    w_tab_pend   = COUNT_BITS'(1);
                    w_tab_wkr    = 3'(r_best_idx);
                    w_ent_set    = 1'b1;
                    w_ld_go      = 1'b1;
                    w_ld_tgt     = r_best_idx;
                    w_res.kind   = KIND_ASSIGNED;
                    w_res.worker = 3'(r_best_idx);
                end else begin
                    w_res.kind   = KIND_REJECTED;
                end
            end else begin
                w_ld_go  = r_job.wid_known;
                w_ld_tgt = WIDX'(r_job.worker_id);
                w_ld_inc = 1'b0;
                if (r_found) begin
                    if (r_hit_pend <= COUNT_BITS'(1)) begin
                        w_ent_clr = 1'b1;
                    end else begin
                        w_tab_we   = 1'b1;
                        w_tab_pend = r_hit_pend - COUNT_BITS'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        if (r_tgt_inc) begin
            w_load_nxt = (&r_rd_load) ? r_rd_load : r_rd_load + COUNT_BITS'(1);
        end else begin
            w_load_nxt = (r_rd_load != '0) ? r_rd_load - COUNT_BITS'(1) : r_rd_load;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ent_vld <= '0;
            r_lvld    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ent_set) begin
                r_ent_vld[w_tab_idx] <= 1'b1;
            end
            if (w_ent_clr) begin
                r_ent_vld[r_hit_idx] <= 1'b0;
            end
            if (r_state == ST_LOAD_WR) begin
                r_lvld[r_tgt] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_job        <= i_job;
                r_n          <= w_n_clamp;
                r_k          <= '0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end
            ST_SCAN: begin
                r_k <= r_k + KBITS'(1);
                if (w_hit && !r_found) begin
                    r_found    <= 1'b1;
                    r_hit_idx  <= SIDX'(w_t);
                    r_hit_pend <= r_rd_pend;
                    r_hit_wkr  <= r_rd_wkr;
                end
                if (w_free && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= SIDX'(w_t);
                end
                if (w_ld_in && w_better) begin
                    r_best     <= r_rd_load;
                    r_best_idx <= WIDX'(w_t);
                end
            end
            ST_DECIDE: begin
                r_tgt     <= w_ld_tgt;
                r_tgt_inc <= w_ld_inc;
                r_res     <= w_res;
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    // affinity table port
    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            mem_pend[w_tab_idx] <= w_tab_pend;
            if (w_tab_new) begin
                mem_src[w_tab_idx] <= r_job.source_id;
                mem_wkr[w_tab_idx] <= w_tab_wkr;
            end
        end
        r_rd_src  <= mem_src[w_taddr];
        r_rd_pend <= mem_pend[w_taddr];
        r_rd_wkr  <= mem_wkr[w_taddr];
    end

    // load port, unwritten workers read as zero
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD_WR) begin
            mem_load[r_tgt] <= w_load_nxt;
        end
        r_rd_load <= r_lvld[w_laddr] ? mem_load[w_laddr] : '0;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

FILE: hdl/affinity_least_loaded_dispatcher.sv
// the back engine walks the affinity table one entry per cycle and handles one item at a time,
//   taking the next from the queue only after its result is loaded into the result register
// the front register and two-entry queue take up to three items while the engine is busy
// reset: synchronous active-low i_rst_n clears loads, affinity entries, queue and
//   result register; active worker count returns to eight
module affinity_least_loaded_dispatcher #(
    parameter int WORKERS    = 8,
    parameter int SOURCES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [alld_pkg::CFG_BITS-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  alld_pkg::t_in_item            i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output alld_pkg::t_out_item           o_result
);
    import alld_pkg::*;

    // active worker count register
    logic [CFG_BITS-1:0] r_active;

    // front to queue
    logic fr_vld;
    t_job fr_job;
    logic q_full;

    // queue to back engine
    logic q_empty;
    logic q_pop;
    t_job q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // front: take items from the port and mark submit or finish
    alld_front #(
        .WORKERS (WORKERS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_job_vld  (fr_vld),
        .o_job      (fr_job),
        .i_job_full (q_full)
    );

    // short queue so the front keeps taking items while the engine scans
    alld_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (fr_vld),
        .i_push_job (fr_job),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    // back: table lookup, least-loaded pick, count updates, result register
    alld_back #(
        .WORKERS    (WORKERS),
        .SOURCES    (SOURCES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_active    (r_active),
        .i_job       (q_head),
        .i_job_empty (q_empty),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result)
    );

    // rejected and done items never name a worker
    a_idle_worker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.kind != KIND_ASSIGNED) |-> o_result.worker == 3'd0)
        else $error("non-assigned item carries a worker");

    // an assigned worker always exists
    a_worker_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.kind == KIND_ASSIGNED)
        |-> (WORKERS >= 8) || (int'(o_result.worker) < WORKERS))
        else $error("item assigned to a missing worker");

    // a full queue that is not popped stays full
    a_queue_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full && !q_pop |=> q_full)
        else $error("queue lost an entry while full");

endmodule
